@@ hw/rtl/ftld_pkg.sv @@
// ----------------------------------------------------------------------------
// ftld_pkg
// Shared widths and fixed-point coefficients of the four-tank level-rate unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ftld_pkg;
  localparam int LevelW  = 16;
  localparam int RateW   = 24;
  localparam int ScaleW  = 27;  // 1962 * 65535 < 2^27
  localparam int SqArgW  = 44;  // 1962 * 65535 << 16 < 2^43, held as 44 bits
  localparam int QW      = 22;
  localparam int SqrtBitsPerStage = 2;  // result bits settled per stage
  localparam int SqrtStages = QW / SqrtBitsPerStage;
  localparam int CoefW   = 25;
  localparam int TwoG    = 1962;

  localparam logic [CoefW-1:0] OutA1     = 25'd680676;
  localparam logic [CoefW-1:0] OutA2     = 25'd478151;
  localparam logic [CoefW-1:0] PumpT1V1  = 25'd12944341;
  localparam logic [CoefW-1:0] PumpT2V2  = 25'd9383497;
  localparam logic [CoefW-1:0] PumpT3V2  = 25'd20817170;
  localparam logic [CoefW-1:0] PumpT4V1  = 25'd15013931;

  localparam int ProdW = CoefW + QW;   // 47 bits
  localparam int TermW = ProdW - 20 + 1;

  typedef struct packed {
    logic [SqArgW-1:0] rem;
    logic [QW-1:0]     root;
  } sqrt_st_t;
endpackage
`default_nettype wire

@@ hw/rtl/four_tank_level_derivative_top.sv @@
// ----------------------------------------------------------------------------
// four_tank_level_derivative_top
// Quadruple-tank model right-hand side: four level rates per transaction.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while the pipe advances; pipeline: argument
// scale, eleven square-root stages of two bits each, coefficient multiply, sum,
// saturate. The whole pipe advances when the output register is free or
// taken; no internal state beyond the pipeline.
`default_nettype none
module four_tank_level_derivative_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // level_one, level_two, level_three, level_four, pump_volt_one, pump_volt_two
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // rate_one, rate_two, rate_three, rate_four
  output logic [95:0]      m_tdata
);
  localparam int S   = ftld_pkg::SqrtStages;
  localparam int LAT = S + 4;
  localparam int TW  = ftld_pkg::TermW;
  localparam int QW  = ftld_pkg::QW;
  localparam int SW  = ftld_pkg::ScaleW;

  logic adv;
  logic [LAT-1:0] vld;
  assign adv = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], s_tvalid};
  end

  // stage 0: argument scale
  logic [ftld_pkg::SqArgW-1:0] arg_r [4];
  logic [15:0] v_r [S+1][2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++)
        arg_r[i] <= {(ftld_pkg::SqArgW-SW-16)'(0),
                     SW'(SW'(s_tdata[16*i +: 16]) * SW'(ftld_pkg::TwoG)), 16'b0};
      v_r[0][0] <= s_tdata[79:64];
      v_r[0][1] <= s_tdata[95:80];
      for (int k = 1; k <= S; k++) v_r[k] <= v_r[k-1];
    end
  end

  logic [QW-1:0] q [4];
  for (genvar t = 0; t < 4; t++) begin : g_sq
    ftld_sqrt u_sqrt (.clk(clk), .adv(adv), .arg(arg_r[t]), .root(q[t]));
  end

  // multiply stage
  logic [ftld_pkg::ProdW-1:0] p_q [4];
  logic [ftld_pkg::ProdW-1:0] p_v [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      p_q[0] <= ftld_pkg::OutA1 * q[0];
      p_q[1] <= ftld_pkg::OutA2 * q[1];
      p_q[2] <= ftld_pkg::OutA1 * q[2];
      p_q[3] <= ftld_pkg::OutA2 * q[3];
      p_v[0] <= ftld_pkg::PumpT1V1 * v_r[S][0];
      p_v[1] <= ftld_pkg::PumpT2V2 * v_r[S][1];
      p_v[2] <= ftld_pkg::PumpT3V2 * v_r[S][1];
      p_v[3] <= ftld_pkg::PumpT4V1 * v_r[S][0];
    end
  end

  function automatic logic signed [TW:0] rnd(input logic [ftld_pkg::ProdW-1:0] p);
    logic [ftld_pkg::ProdW:0] s;
    s = {1'b0, p} + (ftld_pkg::ProdW+1)'(1 << 19);
    return $signed({1'b0, s[ftld_pkg::ProdW:20]});
  endfunction

  // sum stage
  logic signed [TW+2:0] sum_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r[0] <= (TW+3)'(rnd(p_v[0])) + (TW+3)'(rnd(p_q[2])) - (TW+3)'(rnd(p_q[0]));
      sum_r[1] <= (TW+3)'(rnd(p_v[1])) + (TW+3)'(rnd(p_q[3])) - (TW+3)'(rnd(p_q[1]));
      sum_r[2] <= (TW+3)'(rnd(p_v[2])) - (TW+3)'(rnd(p_q[2]));
      sum_r[3] <= (TW+3)'(rnd(p_v[3])) - (TW+3)'(rnd(p_q[3]));
    end
  end

  // saturate into output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (sum_r[i] > (TW+3)'(8388607)) m_tdata[24*i +: 24] <= 24'h7FFFFF;
        else if (sum_r[i] < -(TW+3)'(8388608)) m_tdata[24*i +: 24] <= 24'h800000;
        else m_tdata[24*i +: 24] <= sum_r[i][23:0];
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("stall without pending output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0]) else $error("transaction dropped");
endmodule
`default_nettype wire

@@ hw/rtl/ftld_sqrt.sv @@
// ----------------------------------------------------------------------------
// ftld_sqrt
// Pipelined restoring integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ftld_sqrt (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire logic [ftld_pkg::SqArgW-1:0] arg,
  output logic      [ftld_pkg::QW-1:0]     root
);
  localparam int S = ftld_pkg::SqrtStages;
  localparam int B = ftld_pkg::SqrtBitsPerStage;

  logic [ftld_pkg::SqArgW-1:0] x_r   [S];
  ftld_pkg::sqrt_st_t          st_r  [S];

  function automatic ftld_pkg::sqrt_st_t step(
    input ftld_pkg::sqrt_st_t s, input logic [ftld_pkg::SqArgW-1:0] x, input int k);
    ftld_pkg::sqrt_st_t o;
    logic [ftld_pkg::SqArgW+1:0] trial;
    logic [ftld_pkg::SqArgW+1:0] cur;
    o = s;
    cur = {o.rem, x[2*k +: 2]};
    trial = (ftld_pkg::SqArgW+2)'({o.root, 2'b01});
    if (cur >= trial) begin
      cur = cur - trial;
      o.root = {o.root[ftld_pkg::QW-2:0], 1'b1};
    end else begin
      o.root = {o.root[ftld_pkg::QW-2:0], 1'b0};
    end
    o.rem = cur[ftld_pkg::SqArgW-1:0];
    return o;
  endfunction

  for (genvar g = 0; g < S; g++) begin : g_stage
    ftld_pkg::sqrt_st_t s_in, s_out;
    logic [ftld_pkg::SqArgW-1:0] x_in;
    if (g == 0) begin : g_head
      assign s_in = '0;
      assign x_in = arg;
    end else begin : g_link
      assign s_in = st_r[g-1];
      assign x_in = x_r[g-1];
    end
    always_comb begin
      s_out = s_in;
      for (int j = 0; j < B; j++) begin
        s_out = step(s_out, x_in, ftld_pkg::QW - 1 - (g * B + j));
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g] <= s_out;
        x_r[g]  <= x_in;
      end
    end
  end

  assign root = st_r[S-1].root;
endmodule
`default_nettype wire

@@ tb/four_tank_level_derivative_top_tb.sv @@
// ----------------------------------------------------------------------------
// four_tank_level_derivative_top_tb
// Drives level/pump transactions into the four-tank rate unit and checks every
// output transaction against a behavioral model of the fixed-point equations,
// with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module four_tank_level_derivative_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pump_volt_two;
    logic [15:0] pump_volt_one;
    logic [15:0] level_four;
    logic [15:0] level_three;
    logic [15:0] level_two;
    logic [15:0] level_one;
  } tank_in_t;

  typedef struct packed {
    logic signed [23:0] rate_four;
    logic signed [23:0] rate_three;
    logic signed [23:0] rate_two;
    logic signed [23:0] rate_one;
  } tank_rate_t;

  typedef struct {
    tank_in_t   stim;
    bit         has_exp;
    tank_rate_t rates;
  } stim_row_t;

  localparam int NumRandom = 1130;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;

  tank_rate_t rates_pending[$];
  int         fail_cnt;
  bit         quiet_phase;

  four_tank_level_derivative_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned outlet_speed(logic [15:0] lvl);
    longint unsigned x, res, bitv;
    x = (longint'(ftld_pkg::TwoG) * lvl) << 16;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint rounded_term(longint unsigned coef, longint unsigned x);
    return longint'((coef * x + (64'd1 << 19)) >> 20);
  endfunction

  function automatic logic [23:0] clamp_rate(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic tank_rate_t tank_rates(tank_in_t t);
    tank_rate_t r;
    longint o1, o2, o3, o4;
    o1 = rounded_term(ftld_pkg::OutA1, outlet_speed(t.level_one));
    o3 = rounded_term(ftld_pkg::OutA1, outlet_speed(t.level_three));
    o2 = rounded_term(ftld_pkg::OutA2, outlet_speed(t.level_two));
    o4 = rounded_term(ftld_pkg::OutA2, outlet_speed(t.level_four));
    r.rate_one   = clamp_rate(-o1 + o3 + rounded_term(ftld_pkg::PumpT1V1, t.pump_volt_one));
    r.rate_two   = clamp_rate(-o2 + o4 + rounded_term(ftld_pkg::PumpT2V2, t.pump_volt_two));
    r.rate_three = clamp_rate(-o3 + rounded_term(ftld_pkg::PumpT3V2, t.pump_volt_two));
    r.rate_four  = clamp_rate(-o4 + rounded_term(ftld_pkg::PumpT4V1, t.pump_volt_one));
    return r;
  endfunction

  function automatic tank_in_t random_levels();
    tank_in_t t;
    logic [15:0] f[6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 5))
        0: f[i] = 16'h0000;
        1: f[i] = 16'hFFFF;
        2: f[i] = 16'($urandom_range(0, 255));
        default: f[i] = 16'($urandom);
      endcase
    end
    t = {f[5], f[4], f[3], f[2], f[1], f[0]};
    return t;
  endfunction

  // Drive one transaction; expectation is queued at acceptance.
  task automatic send_levels(tank_in_t t, bit has_exp, tank_rate_t exp_r);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    if (has_exp && exp_r !== tank_rates(t)) begin
      $error("directed row expectation disagrees with model");
      fail_cnt++;
    end
    rates_pending.push_back(has_exp ? exp_r : tank_rates(t));
  endtask

  // Sink side: random stall bursts.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 9);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Output checker.
  always @(posedge clk) begin
    tank_rate_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (rates_pending.size() == 0) begin
        $error("unexpected output transaction %h", m_tdata);
        fail_cnt++;
      end else begin
        want = rates_pending.pop_front();
        if (got.rate_one !== want.rate_one) begin
          $error("rate_one exp %0d got %0d", want.rate_one, got.rate_one);
          fail_cnt++;
        end
        if (got.rate_two !== want.rate_two) begin
          $error("rate_two exp %0d got %0d", want.rate_two, got.rate_two);
          fail_cnt++;
        end
        if (got.rate_three !== want.rate_three) begin
          $error("rate_three exp %0d got %0d", want.rate_three, got.rate_three);
          fail_cnt++;
        end
        if (got.rate_four !== want.rate_four) begin
          $error("rate_four exp %0d got %0d", want.rate_four, got.rate_four);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    tank_rate_t none;
    int wait_cnt;
    none = '0;
    fail_cnt = 0;
    quiet_phase = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // all zero: every rate zero
    rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, '0});
    // pumps only at full scale
    rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, none});
    rows.push_back('{'{16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, none});
    rows.push_back('{'{16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, none});
    // each level alone at full scale
    rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF}, 1'b0, none});
    rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0}, 1'b0, none});
    rows.push_back('{'{16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0}, 1'b0, none});
    rows.push_back('{'{16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0}, 1'b0, none});
    // everything full scale, then lowest nonzero values, then mid-scale 0x8000
    rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                     1'b0, none});
    rows.push_back('{'{16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1}, 1'b0, none});
    rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
                     1'b0, none});
    // upper tanks full, pumps off: most negative rates three and four; then alternating bit patterns
    rows.push_back('{'{16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0}, 1'b0, none});
    rows.push_back('{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
                     1'b0, none});
    rows.push_back('{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
                     1'b0, none});

    foreach (rows[i]) send_levels(rows[i].stim, rows[i].has_exp, rows[i].rates);

    // drain once with the sender held off
    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (rates_pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 150) quiet_phase = 1'b1;
      send_levels(random_levels(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (rates_pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (30) @(posedge clk);
    if (fail_cnt == 0 && rates_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (rates_pending.size() != 0)
        $error("%0d output transactions never arrived", rates_pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
